/* hw/rtl/lurw_pkg.sv */
package lurw_pkg;

    // Longest string length kept; later bytes of a string are dropped
    localparam int MAX_LEN = 1024;

    localparam int CHAR_W  = 8;
    localparam int CHARS   = 1 << CHAR_W;
    localparam int LEN_W   = 11;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]  t_len;

    // Request waiting for its table read to return
    typedef struct packed {
        logic  valid;
        t_char char_code;
        logic  last;
        logic  fwd_hit;
        t_addr fwd_pos;
    } t_s1;

    // Table write from the update stage
    typedef struct packed {
        logic  en;
        t_char addr;
        t_addr data;
    } t_wr;

endpackage

/* hw/rtl/lurw_if.sv */
interface lurw_in_if;
    logic                        valid;
    logic                        ready;
    logic [lurw_pkg::CHAR_W-1:0] char_code;
    logic                        end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface lurw_out_if;
    logic                       valid;
    logic                       ready;
    logic [lurw_pkg::LEN_W-1:0] best_length;
    logic [lurw_pkg::LEN_W-1:0] window_length;
    logic                       string_done;
    logic                       overflow;

    modport source (output valid, output best_length, output window_length,
                    output string_done, output overflow, input ready);
    modport sink   (input valid, input best_length, input window_length,
                    input string_done, input overflow, output ready);
endinterface

/* hw/rtl/longest_unique_run_window_top.sv */
// Channel  | Dir | Fields                                           | Request
// i_in     | in  | char_code, end_of_string                         | one byte
// o_out    | out | best_length, window_length, string_done, overflow | one result per byte
//
// One byte per cycle unless o_out stalls; path: read slot, then output register.
// The rate is set by the last-position table: one read and one write port, one
// access of each per byte, with a same-entry write forwarded to the next byte.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears string state;
// the table itself needs no clearing, seen flags cover it.
// A stalled output register holds the request behind it and then i_in.ready.
module longest_unique_run_window_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lurw_in_if.sink    i_in,
    lurw_out_if.source o_out
);
    import lurw_pkg::*;

    t_s1   s1;
    t_wr   wr;
    logic  adv;
    logic  rd_en;
    t_char rd_addr;
    t_addr rd_data;

    lurw_issue u_issue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_adv     (adv),
        .i_wr      (wr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_s1      (s1)
    );

    lurw_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CHARS)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lurw_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_rd_data (rd_data),
        .o_out     (o_out),
        .o_adv     (adv),
        .o_wr      (wr)
    );

    // A blocked output register must hold back a waiting request
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1.valid && o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while the read slot is blocked");

    // A write to the entry being read must be forwarded
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && wr.en && (wr.addr == i_in.char_code)
        |=> s1.fwd_hit)
        else $error("same-entry write not forwarded");

    // The current window never beats the best one
    a_win_le_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.window_length <= o_out.best_length)
        else $error("window length above best length");

    // Table writes happen only when a request moves on
    a_write_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> adv && s1.valid)
        else $error("table write without an advancing request");

endmodule

/* hw/rtl/lurw_ram.sv */
module lurw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/lurw_issue.sv */
module lurw_issue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lurw_in_if.sink          i_in,
    input  logic             i_adv,
    input  lurw_pkg::t_wr    i_wr,
    output logic             o_rd_en,
    output lurw_pkg::t_char  o_rd_addr,
    output lurw_pkg::t_s1    o_s1
);
    import lurw_pkg::*;

    t_s1  r_s1;
    logic accept;

    // Take a new request when the read slot is free or drains this cycle
    assign i_in.ready = !r_s1.valid || i_adv;
    assign accept     = i_in.valid && i_in.ready;

    // Issue the table read with the request
    assign o_rd_en   = accept;
    assign o_rd_addr = i_in.char_code;

    // Hold the read slot; forward a write that lands on the same entry this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (accept) begin
            r_s1.valid     <= 1'b1;
            r_s1.char_code <= i_in.char_code;
            r_s1.last      <= i_in.end_of_string;
            r_s1.fwd_hit   <= i_wr.en && (i_wr.addr == i_in.char_code);
            r_s1.fwd_pos   <= i_wr.data;
        end else if (i_adv) begin
            r_s1.valid <= 1'b0;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* hw/rtl/lurw_update.sv */
module lurw_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lurw_pkg::t_s1   i_s1,
    input  lurw_pkg::t_addr i_rd_data,
    lurw_out_if.source      o_out,
    output logic            o_adv,
    output lurw_pkg::t_wr   o_wr
);
    import lurw_pkg::*;

    t_pos             r_pos;
    t_addr            r_ws;
    t_pos             r_best;
    logic             r_ovf;
    logic [CHARS-1:0] r_seen;

    logic             r_out_valid;
    t_len             r_out_best;
    t_len             r_out_win;
    logic             r_out_done;
    logic             r_out_ovf;

    logic             full;
    logic             seen;
    t_addr            last_pos;
    t_addr            n_ws;
    t_pos             n_pos;
    t_pos             n_best;
    logic             n_ovf;
    t_pos             win;

    // Advance when the output register is empty or being taken
    assign o_adv = i_s1.valid && (!r_out_valid || o_out.ready);

    // Read-modify of the window state for the current request
    always_comb begin
        full     = (r_pos >= POS_W'(MAX_LEN));
        seen     = r_seen[i_s1.char_code];
        last_pos = i_s1.fwd_hit ? i_s1.fwd_pos : i_rd_data;
        n_ws     = r_ws;
        n_pos    = r_pos;
        n_best   = r_best;
        n_ovf    = r_ovf;
        win      = r_pos - POS_W'(r_ws);
        if (full) begin
            n_ovf = 1'b1;
        end else begin
            if (seen && (last_pos >= r_ws)) begin
                n_ws = ADDR_W'(POS_W'(last_pos) + POS_W'(1));
            end
            n_pos = r_pos + POS_W'(1);
            win   = n_pos - POS_W'(n_ws);
            if (win > r_best) begin
                n_best = win;
            end
        end
    end

    // Write back the last position of this character
    assign o_wr.en   = o_adv && !full;
    assign o_wr.addr = i_s1.char_code;
    assign o_wr.data = r_pos[ADDR_W-1:0];

    // Update string state; drop it all after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ws   <= '0;
            r_best <= '0;
            r_ovf  <= 1'b0;
            r_seen <= '0;
        end else if (o_adv) begin
            if (i_s1.last) begin
                r_pos  <= '0;
                r_ws   <= '0;
                r_best <= '0;
                r_ovf  <= 1'b0;
                r_seen <= '0;
            end else begin
                r_pos  <= n_pos;
                r_ws   <= n_ws;
                r_best <= n_best;
                r_ovf  <= n_ovf;
                if (!full) begin
                    r_seen[i_s1.char_code] <= 1'b1;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out_best <= LEN_W'(n_best);
            r_out_win  <= LEN_W'(win);
            r_out_done <= i_s1.last;
            r_out_ovf  <= n_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.best_length   = r_out_best;
    assign o_out.window_length = r_out_win;
    assign o_out.string_done   = r_out_done;
    assign o_out.overflow      = r_out_ovf;

endmodule
